>>> sv/knn_pkg.sv
package knn_pkg;

  localparam int SAMPLE_CAPACITY_DEF = 1024;
  localparam int FEATURE_COUNT_DEF   = 9;
  localparam int CLASS_COUNT_DEF     = 3;
  localparam int FEAT_MAX            = 9;
  localparam int FEAT_W              = 8;
  localparam int DIST_W              = 20;
  localparam int KCNT_W              = 11;
  localparam int CORR_W              = 16;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_CLASSIFY = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

endpackage

>>> sv/knn_majority_classifier.sv
// channel  | direction | handshake                | payload
// in_      | input     | in_valid / in_ready      | command, feature_0..8, class_label
// out_     | output    | out_valid / out_ready    | predicted_class, winning_votes,
//          |           |                          | label_matched, correct_total
// cfg_     | input     | cfg_wr_en (no wait)      | neighbour_count
// clear and nop items finish at accept; a load item then writes its features in S_STORE
// a classify item, for n samples loaded, k voters (capped at n) and F features, runs a distance
// pass in which each feature costs a read state and an accumulate state, then a selection
// that scans the distance memory once per voter
// rst_n is synchronous; memories are not cleared, only the sample count and correct total.
// the result waits in an output register; a new item is taken once it leaves.
module knn_majority_classifier
  import knn_pkg::*;
#(
  parameter int SAMPLE_CAPACITY = SAMPLE_CAPACITY_DEF,
  parameter int FEATURE_COUNT   = FEATURE_COUNT_DEF,
  parameter int CLASS_COUNT     = CLASS_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_command,
  input  logic signed [FEAT_W-1:0] in_feature_0,
  input  logic signed [FEAT_W-1:0] in_feature_1,
  input  logic signed [FEAT_W-1:0] in_feature_2,
  input  logic signed [FEAT_W-1:0] in_feature_3,
  input  logic signed [FEAT_W-1:0] in_feature_4,
  input  logic signed [FEAT_W-1:0] in_feature_5,
  input  logic signed [FEAT_W-1:0] in_feature_6,
  input  logic signed [FEAT_W-1:0] in_feature_7,
  input  logic signed [FEAT_W-1:0] in_feature_8,
  input  logic [1:0]               in_class_label,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_predicted_class,
  output logic [KCNT_W-1:0]        out_winning_votes,
  output logic                     out_label_matched,
  output logic [CORR_W-1:0]        out_correct_total,
  input  logic                     cfg_wr_en,
  input  logic [KCNT_W-1:0]        cfg_neighbour_count
);

  localparam int AW   = (SAMPLE_CAPACITY > 1) ? $clog2(SAMPLE_CAPACITY) : 1;
  localparam int NW   = $clog2(SAMPLE_CAPACITY + 1);
  localparam int FW   = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int FAW  = AW + FW;
  localparam int FDEP = SAMPLE_CAPACITY * FEATURE_COUNT;
  localparam int VW   = KCNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_STORE, S_DRD, S_DACC, S_DWR, S_SCAN, S_SWAIT, S_PICK,
    S_VOTE, S_DONE
  } state_t;

  // memories
  logic signed [FEAT_W-1:0] feat_mem [FDEP];
  logic [1:0]               cls_mem  [SAMPLE_CAPACITY];
  logic [DIST_W-1:0]        dist_mem [SAMPLE_CAPACITY];
  // picked flags, one per sample, cleared during the distance pass
  logic                     pick_mem [SAMPLE_CAPACITY];

  logic signed [FEAT_W-1:0] feat_rd;
  logic [1:0]               cls_rd;
  logic [DIST_W-1:0]        dist_rd;
  logic                     pick_rd;

  logic [FAW-1:0]           feat_addr;
  logic                     feat_we;
  logic signed [FEAT_W-1:0] feat_wd;
  logic [AW-1:0]            cls_addr;
  logic                     cls_we;
  logic [AW-1:0]            dist_raddr, dist_waddr;
  logic                     dist_we;
  logic [AW-1:0]            pick_raddr, pick_waddr;
  logic                     pick_we, pick_wd;

  state_t                   state_r;
  logic signed [FEAT_W-1:0] q_r [FEAT_MAX];
  logic [1:0]               q_label_r;
  logic [NW-1:0]            loaded_r;
  logic [CORR_W-1:0]        corr_r;
  logic [KCNT_W-1:0]        k_cfg_r;
  logic [NW-1:0]            idx_r;
  logic [FW-1:0]            fi_r;
  logic [DIST_W-1:0]        acc_r;
  logic [KCNT_W-1:0]        kleft_r;
  logic [NW-1:0]            scan_r;
  logic                     rd_ok_r;
  logic [AW-1:0]            rd_idx_r;
  logic                     have_r;
  logic [AW-1:0]            sel_r;
  logic [DIST_W-1:0]        sel_d_r;
  logic [VW-1:0]            votes_r [3];
  logic [FAW-1:0]           fbase_r;

  logic signed [FEAT_W:0]   diff;
  logic signed [2*FEAT_W+1:0] prod;
  logic [2*FEAT_W-1:0]      sq;
  logic [NW-1:0]            k_eff;
  logic [1:0]               best;
  logic [VW-1:0]            best_v;
  logic                     match;

  always_ff @(posedge clk) begin
    if (feat_we) begin
      feat_mem[feat_addr] <= feat_wd;
    end
    feat_rd <= feat_mem[feat_addr];
  end

  always_ff @(posedge clk) begin
    if (cls_we) begin
      cls_mem[cls_addr] <= q_label_r;
    end
    cls_rd <= cls_mem[cls_addr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= acc_r;
    end
    dist_rd <= dist_mem[dist_raddr];
  end

  always_ff @(posedge clk) begin
    if (pick_we) begin
      pick_mem[pick_waddr] <= pick_wd;
    end
    pick_rd <= pick_mem[pick_raddr];
  end

  assign in_ready = (state_r == S_IDLE) && !out_valid;

  always_comb begin
    diff = {feat_rd[FEAT_W-1], feat_rd} - {q_r[fi_r][FEAT_W-1], q_r[fi_r]};
    prod = diff * diff;
    sq   = prod[2*FEAT_W-1:0];
  end

  always_comb begin
    if (32'(k_cfg_r) > 32'(loaded_r))
      k_eff = loaded_r;
    else
      k_eff = NW'(k_cfg_r);
  end

  always_comb begin
    best   = 2'd0;
    best_v = votes_r[0];
    if (votes_r[1] > best_v) begin
      best   = 2'd1;
      best_v = votes_r[1];
    end
    if (CLASS_COUNT > 2 && votes_r[2] > best_v) begin
      best   = 2'd2;
      best_v = votes_r[2];
    end
    match = (best == q_label_r);
  end

  // memory address and write control
  always_comb begin
    feat_addr  = fbase_r + FAW'(fi_r);
    feat_we    = (state_r == S_STORE);
    feat_wd    = q_r[fi_r];
    cls_addr   = (state_r == S_STORE) ? AW'(loaded_r) : sel_r;
    cls_we     = (state_r == S_STORE) && (fi_r == FW'(FEATURE_COUNT - 1));
    dist_raddr = AW'(scan_r);
    dist_waddr = AW'(idx_r);
    dist_we    = (state_r == S_DWR);
    pick_raddr = AW'(scan_r);
    pick_we    = (state_r == S_DWR) || (state_r == S_PICK);
    pick_waddr = (state_r == S_DWR) ? AW'(idx_r) : sel_r;
    pick_wd    = (state_r == S_PICK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      loaded_r  <= '0;
      corr_r    <= '0;
      k_cfg_r   <= KCNT_W'(1);
      out_valid <= 1'b0;
      fi_r      <= '0;
      fbase_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        k_cfg_r <= cfg_neighbour_count;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            q_r[0] <= in_feature_0;
            q_r[1] <= in_feature_1;
            q_r[2] <= in_feature_2;
            q_r[3] <= in_feature_3;
            q_r[4] <= in_feature_4;
            q_r[5] <= in_feature_5;
            q_r[6] <= in_feature_6;
            q_r[7] <= in_feature_7;
            q_r[8] <= in_feature_8;
            q_label_r <= in_class_label;
            fi_r      <= '0;
            case (cmd_t'(in_command))
              CMD_LOAD: begin
                if (loaded_r < NW'(SAMPLE_CAPACITY)) begin
                  fbase_r <= FAW'(loaded_r) * FAW'(FEATURE_COUNT);
                  state_r <= S_STORE;
                end
              end
              CMD_CLASSIFY: begin
                idx_r      <= '0;
                fbase_r    <= '0;
                acc_r      <= '0;
                votes_r[0] <= '0;
                votes_r[1] <= '0;
                votes_r[2] <= '0;
                state_r    <= S_DRD;
              end
              CMD_CLEAR: begin
                loaded_r <= '0;
                corr_r   <= '0;
              end
              default: ;
            endcase
          end
        end
        S_STORE: begin
          if (fi_r == FW'(FEATURE_COUNT - 1)) begin
            loaded_r <= loaded_r + 1'b1;
            state_r  <= S_IDLE;
          end else begin
            fi_r <= fi_r + 1'b1;
          end
        end
        // distance pass: a read state then an accumulate state per feature
        S_DRD: begin
          if (idx_r == loaded_r) begin
            kleft_r <= KCNT_W'(k_eff);
            state_r <= S_SCAN;
            scan_r  <= '0;
            have_r  <= 1'b0;
            rd_ok_r <= 1'b0;
          end else begin
            state_r <= S_DACC;
          end
        end
        S_DACC: begin
          acc_r <= acc_r + DIST_W'(sq);
          if (fi_r == FW'(FEATURE_COUNT - 1)) begin
            fi_r    <= '0;
            state_r <= S_DWR;
          end else begin
            fi_r    <= fi_r + 1'b1;
            state_r <= S_DRD;
          end
        end
        S_DWR: begin
          acc_r   <= '0;
          idx_r   <= idx_r + 1'b1;
          fbase_r <= fbase_r + FAW'(FEATURE_COUNT);
          state_r <= S_DRD;
        end
        // selection: one pass per voter, reads registered through rd_idx_r and rd_ok_r
        S_SCAN: begin
          if (kleft_r == '0) begin
            state_r <= S_DONE;
          end else begin
            if (rd_ok_r && !pick_rd && (!have_r || dist_rd < sel_d_r)) begin
              have_r  <= 1'b1;
              sel_r   <= rd_idx_r;
              sel_d_r <= dist_rd;
            end
            rd_idx_r <= AW'(scan_r);
            if (scan_r == loaded_r) begin
              rd_ok_r <= 1'b0;
              state_r <= S_SWAIT;
            end else begin
              rd_ok_r <= 1'b1;
              scan_r  <= scan_r + 1'b1;
            end
          end
        end
        S_SWAIT: begin
          state_r <= S_PICK;
        end
        S_PICK: begin
          state_r <= S_VOTE;
        end
        S_VOTE: begin
          if (cls_rd == 2'd0 && CLASS_COUNT > 0) votes_r[0] <= votes_r[0] + 1'b1;
          if (cls_rd == 2'd1 && CLASS_COUNT > 1) votes_r[1] <= votes_r[1] + 1'b1;
          if (cls_rd == 2'd2 && CLASS_COUNT > 2) votes_r[2] <= votes_r[2] + 1'b1;
          kleft_r <= kleft_r - 1'b1;
          scan_r  <= '0;
          have_r  <= 1'b0;
          rd_ok_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_DONE: begin
          out_predicted_class <= best;
          out_winning_votes   <= best_v;
          out_label_matched   <= match;
          if (match && corr_r != '1) begin
            out_correct_total <= corr_r + 1'b1;
            corr_r            <= corr_r + 1'b1;
          end else begin
            out_correct_total <= corr_r;
          end
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
